>>> src/ksr_pkg.sv
// ----------------------------------------------------------------------------
// ksr_pkg: shared types and codes of the keyed record search engine
// Request and result records, mode, option and error codes, and the
// memory port record passed between the sequencer and the byte memory.
// ----------------------------------------------------------------------------
package ksr_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] search_key;
    logic [4:0]  key_bytes;
    logic [31:0] base_address;
    logic [15:0] record_bytes;
    logic [31:0] record_count;
    logic [15:0] key_offset;
    logic [15:0] link_offset;
    logic [2:0]  option_flags;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        found;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [31:0] waddr;
    logic [7:0]  wdata;
    logic [31:0] raddr;
  } mem_req_t;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_BINARY = 2'd2;
  localparam logic [1:0] MODE_LINKED = 2'd3;

  localparam int OPT_INDIRECT = 0;
  localparam int OPT_ZERO_END = 1;
  localparam int OPT_INDEX    = 2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_KEY_SIZE = 2'd1;
  localparam logic [1:0] ERR_BEYOND   = 2'd2;
  localparam logic [1:0] ERR_STEPS    = 2'd3;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

endpackage

>>> src/ksr_mem.sv
// ----------------------------------------------------------------------------
// ksr_mem: search byte memory
// One write and one registered read per cycle. After reset a sweep writes
// zero to every byte, one byte per cycle, while clearing is high.
// ----------------------------------------------------------------------------
module ksr_mem #(
  parameter int MEM_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  ksr_pkg::mem_req_t port,
  output logic [7:0]        rd_data,
  output logic              clearing
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MEM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (port.we) begin
      mem[port.waddr[AW-1:0]] <= port.wdata;
    end
    rd_data <= mem[port.raddr[AW-1:0]];
  end

endmodule

>>> src/keyed_record_search_engine_top.sv
// ----------------------------------------------------------------------------
// keyed_record_search_engine_top: linear, binary and linked record search
// Byte memory with three search walks driven by one byte-wide sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and exactly one
// result follows, shown for a single cycle with done high; the receiver
// cannot stall it, so it must take the result in that cycle. After reset the
// memory is swept to zero, one byte per cycle, and busy stays high throughout.
// A write request, a bad key size and any request rejected up front answer in
// the next cycle. A search reads the single memory port one byte at a time, so
// its length depends on the data: each key byte compared passes the key, read
// and compare states, and closing the comparison a check and the end state (a
// byte string stopping at its first difference goes straight to the end), each
// zero-key byte checked a read and a check, each link pointer four byte reads,
// and each record visited address setup (a binary probe adds a multiply step).
// ----------------------------------------------------------------------------
module keyed_record_search_engine_top #(
  parameter int MEM_BYTES      = 4096,
  parameter int MAX_KEY_BYTES  = 16,
  parameter int MAX_LINK_STEPS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ksr_pkg::item_t    req,
  output logic              busy,
  output logic              done,
  output ksr_pkg::result_t  result
);

  localparam int SW = $clog2(MAX_LINK_STEPS + 1);

  // One-hot sequencer states.
  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_LIN  = 16'b0000_0000_0000_0010,
    S_NEXT = 16'b0000_0000_0000_0100,
    S_BMID = 16'b0000_0000_0000_1000,
    S_BMUL = 16'b0000_0000_0001_0000,
    S_BADD = 16'b0000_0000_0010_0000,
    S_BKA  = 16'b0000_0000_0100_0000,
    S_LNK  = 16'b0000_0000_1000_0000,
    S_CK   = 16'b0000_0001_0000_0000,
    S_CR   = 16'b0000_0010_0000_0000,
    S_CC   = 16'b0000_0100_0000_0000,
    S_CEND = 16'b0000_1000_0000_0000,
    S_ZR   = 16'b0001_0000_0000_0000,
    S_ZC   = 16'b0010_0000_0000_0000,
    S_PR   = 16'b0100_0000_0000_0000,
    S_PC   = 16'b1000_0000_0000_0000
  } state_t;

  state_t            state;
  ksr_pkg::item_t    it;
  ksr_pkg::mem_req_t mreq;
  logic [7:0]        mem_q;
  logic              clearing;

  logic [31:0] idx, limit, lo, hi, mid, prod, rec, ka, la, ptr;
  logic [4:0]  bi;
  logic [1:0]  cres;
  logic [7:0]  pbyte;
  logic [SW-1:0] steps;

  // Shared address adder: the base of the current byte walk plus the byte index.
  logic [31:0] abase, cur_addr;
  logic        fault;
  logic [4:0]  sh;
  logic [7:0]  kbyte, pb;
  logic [32:0] mid_sum;
  logic        indirect, zero_end, want_idx;
  logic [31:0] miss_val;
  logic        accept, bad_size, wr_fault;

  ksr_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .port     (mreq),
    .rd_data  (mem_q),
    .clearing (clearing)
  );

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;

  assign indirect = it.option_flags[ksr_pkg::OPT_INDIRECT];
  assign zero_end = it.option_flags[ksr_pkg::OPT_ZERO_END];
  assign want_idx = it.option_flags[ksr_pkg::OPT_INDEX];
  assign miss_val = (it.mode != ksr_pkg::MODE_LINKED && want_idx) ? 32'hFFFF_FFFF : 32'h0;

  always_comb begin
    priority if (state == S_CK) begin
      abase = it.search_key;
    end else if (state == S_PR) begin
      abase = la;
    end else begin
      abase = ka;
    end
  end

  assign cur_addr = abase + {27'd0, bi};
  assign fault    = cur_addr >= 32'(MEM_BYTES);

  // Direct keys are compared big-endian, most significant byte first.
  assign sh    = it.key_bytes - 5'd1 - bi;
  assign kbyte = 8'(it.search_key >> {sh, 3'b000});
  assign pb    = indirect ? pbyte : kbyte;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};

  assign wr_fault = req.base_address >= 32'(MEM_BYTES);
  assign bad_size = req.option_flags[ksr_pkg::OPT_INDIRECT] ?
                    (32'(req.key_bytes) > 32'(MAX_KEY_BYTES)) :
                    (req.key_bytes != 5'd1 && req.key_bytes != 5'd2 && req.key_bytes != 5'd4);

  always_comb begin
    mreq.we    = accept && (req.mode == ksr_pkg::MODE_WRITE) && !wr_fault;
    mreq.waddr = req.base_address;
    mreq.wdata = req.write_byte;
    mreq.raddr = cur_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            it <= req;
            if (req.mode == ksr_pkg::MODE_WRITE) begin
              result <= '{32'h0, 1'b0, wr_fault ? ksr_pkg::ERR_BEYOND : ksr_pkg::ERR_NONE};
              done   <= 1'b1;
            end else if (bad_size) begin
              result <= '{32'h0, 1'b0, ksr_pkg::ERR_KEY_SIZE};
              done   <= 1'b1;
            end else if (req.mode == ksr_pkg::MODE_LINEAR) begin
              idx   <= 32'h0;
              rec   <= req.base_address;
              limit <= (req.record_bytes == 16'h0 && req.record_count > 32'd1) ?
                       32'd1 : req.record_count;
              state <= S_LIN;
            end else if (req.mode == ksr_pkg::MODE_BINARY) begin
              lo    <= 32'h0;
              hi    <= req.record_count;
              state <= S_BMID;
            end else begin
              rec   <= req.base_address;
              steps <= '0;
              state <= S_LNK;
            end
          end
        end
        S_LIN: begin
          if (idx < limit) begin
            ka    <= rec + {16'h0, it.key_offset};
            bi    <= 5'd0;
            cres  <= ksr_pkg::CMP_EQ;
            state <= S_CK;
          end else begin
            result <= '{miss_val, 1'b0, ksr_pkg::ERR_NONE};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_NEXT: begin
          if (it.mode == ksr_pkg::MODE_LINEAR) begin
            idx   <= idx + 32'd1;
            rec   <= rec + {16'h0, it.record_bytes};
            state <= S_LIN;
          end else begin
            bi    <= 5'd0;
            ptr   <= 32'h0;
            state <= S_PR;
          end
        end
        S_BMID: begin
          if (lo < hi) begin
            mid   <= mid_sum[32:1];
            state <= S_BMUL;
          end else begin
            result <= '{miss_val, 1'b0, ksr_pkg::ERR_NONE};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_BMUL: begin
          prod  <= 32'(mid * {16'h0, it.record_bytes});
          state <= S_BADD;
        end
        S_BADD: begin
          rec   <= it.base_address + prod;
          state <= S_BKA;
        end
        S_BKA: begin
          ka    <= rec + {16'h0, it.key_offset};
          bi    <= 5'd0;
          cres  <= ksr_pkg::CMP_EQ;
          state <= S_CK;
        end
        S_LNK: begin
          if (rec == 32'h0) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_NONE};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (steps >= SW'(MAX_LINK_STEPS)) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_STEPS};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            steps <= steps + 1'b1;
            ka    <= rec + {16'h0, it.key_offset};
            la    <= rec + {16'h0, it.link_offset};
            bi    <= 5'd0;
            cres  <= ksr_pkg::CMP_EQ;
            state <= S_CK;
          end
        end
        S_CK: begin
          // Indirect keys read the search key byte here; direct keys ignore that byte.
          if (bi == it.key_bytes) begin
            state <= S_CEND;
          end else if (indirect && fault) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_BEYOND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_CR;
          end
        end
        S_CR: begin
          pbyte <= mem_q;
          if (fault) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_BEYOND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_CC;
          end
        end
        S_CC: begin
          bi    <= bi + 5'd1;
          state <= S_CK;
          if (cres == ksr_pkg::CMP_EQ && pb != mem_q) begin
            cres <= (pb < mem_q) ? ksr_pkg::CMP_LT : ksr_pkg::CMP_GT;
            // A byte string stops at its first difference; a direct key
            // still reads all of its bytes.
            if (indirect) begin
              state <= S_CEND;
            end
          end
        end
        S_CEND: begin
          if (cres == ksr_pkg::CMP_EQ) begin
            if (it.mode == ksr_pkg::MODE_LINEAR) begin
              result <= '{want_idx ? idx : rec, 1'b1, ksr_pkg::ERR_NONE};
            end else if (it.mode == ksr_pkg::MODE_BINARY) begin
              result <= '{want_idx ? mid : rec, 1'b1, ksr_pkg::ERR_NONE};
            end else begin
              result <= '{rec, 1'b1, ksr_pkg::ERR_NONE};
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (it.mode == ksr_pkg::MODE_BINARY) begin
            if (cres == ksr_pkg::CMP_LT) begin
              hi <= mid;
            end else begin
              lo <= mid + 32'd1;
            end
            state <= S_BMID;
          end else if (zero_end) begin
            bi    <= 5'd0;
            state <= S_ZR;
          end else begin
            state <= S_NEXT;
          end
        end
        S_ZR: begin
          if (bi == it.key_bytes) begin
            result <= '{miss_val, 1'b0, ksr_pkg::ERR_NONE};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (fault) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_BEYOND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_ZC;
          end
        end
        S_ZC: begin
          if (mem_q != 8'h00) begin
            state <= S_NEXT;
          end else begin
            bi    <= bi + 5'd1;
            state <= S_ZR;
          end
        end
        S_PR: begin
          if (bi == 5'd4) begin
            rec   <= ptr;
            state <= S_LNK;
          end else if (fault) begin
            result <= '{32'h0, 1'b0, ksr_pkg::ERR_BEYOND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_PC;
          end
        end
        S_PC: begin
          ptr   <= {ptr[23:0], mem_q};
          bi    <= bi + 5'd1;
          state <= S_PR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever raised as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while a search is still running");

  // Every accepted request either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted request neither answered nor in progress");

  // A found record never carries an error.
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> result.error_code == ksr_pkg::ERR_NONE)
    else $error("found result with an error code");

  // Nothing is accepted while the memory is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("request accepted during memory clearing");

endmodule

>>> bench/tb_keyed_record_search_engine_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_record_search_engine_top: self-checking bench of the search engine
// Walks a table of directed requests, then builds random record tables and
// linked lists in memory and searches them, mixed with random noise. Each
// result is checked against a set value or an in-bench model of memory and walks.
// ----------------------------------------------------------------------------
module tb_keyed_record_search_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_SIZE   = 4096;
  localparam int KEY_MAX    = 16;
  localparam int STEP_MAX   = 4096;
  // A quiet stretch of this length, longer than any looping list or long scan
  // should run, means the block is stuck.
  localparam int QUIET_MAX  = 2000000;
  localparam int RAND_ITEMS = 450;

  logic             clk;
  logic             rst;
  logic             start;
  ksr_pkg::item_t   req;
  logic             busy;
  logic             done;
  ksr_pkg::result_t result;

  keyed_record_search_engine_top dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the searchable memory and the fault flag of the walk.
  logic [7:0]       mem_img [0:MEM_SIZE-1];
  bit               rd_fault;
  ksr_pkg::result_t expected_q[$];
  int               mismatches;
  int               quiet_cycles;
  int               burst_left;
  int               random_sent;

  function automatic logic [7:0] peek(logic [31:0] a);
    if (a >= MEM_SIZE) begin
      rd_fault = 1'b1;
      return 8'h00;
    end
    return mem_img[a];
  endfunction

  // Orders the search key against the record key: -1, 0 or 1.
  function automatic int key_order(logic [31:0] key, logic [31:0] addr,
                                   logic [4:0] n, bit indirect);
    logic [7:0]  p;
    logic [7:0]  q;
    logic [31:0] field;
    logic [31:0] probe;
    if (indirect) begin
      for (int i = 0; i < n; i++) begin
        p = peek(key + 32'(i));
        q = peek(addr + 32'(i));
        if (rd_fault) return 0;
        if (p != q) return (p < q) ? -1 : 1;
      end
      return 0;
    end
    field = '0;
    for (int i = 0; i < n; i++) field = (field << 8) | 32'(peek(addr + 32'(i)));
    probe = (n == 5'd1) ? {24'h0, key[7:0]} : (n == 5'd2) ? {16'h0, key[15:0]} : key;
    return (probe < field) ? -1 : (probe > field) ? 1 : 0;
  endfunction

  function automatic bit key_all_zero(logic [31:0] addr, logic [4:0] n);
    for (int i = 0; i < n; i++) begin
      if (peek(addr + 32'(i)) != 8'h00) return 1'b0;
      if (rd_fault) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ksr_pkg::result_t make_result(logic [31:0] v, logic f, logic [1:0] e);
    ksr_pkg::result_t r;
    r.result_value = v;
    r.found        = f;
    r.error_code   = e;
    return r;
  endfunction

  // Expected answer of one request; write requests also update the shadow.
  function automatic ksr_pkg::result_t search_outcome(ksr_pkg::item_t it);
    bit          indirect;
    bit          zero_ends;
    bit          want_index;
    logic [31:0] miss;
    logic [32:0] limit;
    logic [32:0] idx;
    logic [31:0] rec;
    logic [31:0] ka;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    logic [31:0] nxt;
    int          c;
    int          steps;
    indirect   = it.option_flags[ksr_pkg::OPT_INDIRECT];
    zero_ends  = it.option_flags[ksr_pkg::OPT_ZERO_END];
    want_index = it.option_flags[ksr_pkg::OPT_INDEX];
    miss       = want_index ? 32'hFFFF_FFFF : 32'h0;
    rd_fault   = 1'b0;

    if (it.mode == ksr_pkg::MODE_WRITE) begin
      if (it.base_address >= MEM_SIZE) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
      mem_img[it.base_address] = it.write_byte;
      return make_result('0, 1'b0, ksr_pkg::ERR_NONE);
    end

    if (indirect ? (it.key_bytes > KEY_MAX)
                 : !(it.key_bytes inside {5'd1, 5'd2, 5'd4}))
      return make_result('0, 1'b0, ksr_pkg::ERR_KEY_SIZE);

    if (it.mode == ksr_pkg::MODE_LINEAR) begin
      limit = (it.record_bytes == 0 && it.record_count > 1) ? 33'd1
                                                              : {1'b0, it.record_count};
      for (idx = 0; idx < limit; idx++) begin
        rec = it.base_address + idx[31:0] * {16'h0, it.record_bytes};
        ka  = rec + {16'h0, it.key_offset};
        c   = key_order(it.search_key, ka, it.key_bytes, indirect);
        if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
        if (c == 0)
          return make_result(want_index ? idx[31:0] : rec, 1'b1, ksr_pkg::ERR_NONE);
        if (zero_ends) begin
          if (key_all_zero(ka, it.key_bytes)) return make_result(miss, 1'b0, ksr_pkg::ERR_NONE);
          if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
        end
      end
      return make_result(miss, 1'b0, ksr_pkg::ERR_NONE);
    end

    if (it.mode == ksr_pkg::MODE_BINARY) begin
      lo = '0;
      hi = it.record_count;
      while (lo < hi) begin
        mid = 32'(({1'b0, lo} + {1'b0, hi}) >> 1);
        rec = it.base_address + mid * {16'h0, it.record_bytes};
        c   = key_order(it.search_key, rec + {16'h0, it.key_offset}, it.key_bytes, indirect);
        if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
        if (c == 0) return make_result(want_index ? mid : rec, 1'b1, ksr_pkg::ERR_NONE);
        if (c < 0) hi = mid;
        else lo = mid + 1;
      end
      return make_result(miss, 1'b0, ksr_pkg::ERR_NONE);
    end

    rec   = it.base_address;
    steps = 0;
    while (rec != 0) begin
      ka = rec + {16'h0, it.key_offset};
      if (steps >= STEP_MAX) return make_result('0, 1'b0, ksr_pkg::ERR_STEPS);
      steps++;
      c = key_order(it.search_key, ka, it.key_bytes, indirect);
      if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
      if (c == 0) return make_result(rec, 1'b1, ksr_pkg::ERR_NONE);
      if (zero_ends) begin
        if (key_all_zero(ka, it.key_bytes)) return make_result('0, 1'b0, ksr_pkg::ERR_NONE);
        if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
      end
      nxt = '0;
      for (int i = 0; i < 4; i++)
        nxt = (nxt << 8) | 32'(peek(rec + {16'h0, it.link_offset} + 32'(i)));
      if (rd_fault) return make_result('0, 1'b0, ksr_pkg::ERR_BEYOND);
      rec = nxt;
    end
    return make_result('0, 1'b0, ksr_pkg::ERR_NONE);
  endfunction

  function automatic ksr_pkg::item_t make_item(logic [1:0] mode, logic [31:0] key,
                                               logic [4:0] n,
                                               logic [31:0] base, logic [15:0] rsize,
                                               logic [31:0] count, logic [15:0] koff,
                                               logic [15:0] loff, logic [2:0] opt,
                                               logic [7:0] wbyte);
    ksr_pkg::item_t it;
    it.mode         = mode;
    it.search_key   = key;
    it.key_bytes    = n;
    it.base_address = base;
    it.record_bytes = rsize;
    it.record_count = count;
    it.key_offset   = koff;
    it.link_offset  = loff;
    it.option_flags = opt;
    it.write_byte   = wbyte;
    return it;
  endfunction

  // Issues one request in bursts with random gaps, then records the expected
  // result once the request has been taken.
  task automatic issue_request(ksr_pkg::item_t it, bit typed, ksr_pkg::result_t typed_res);
    ksr_pkg::result_t modeled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy);
    modeled = search_outcome(it);
    expected_q.push_back(typed ? typed_res : modeled);
  endtask

  task automatic write_byte_at(logic [31:0] addr, logic [7:0] b);
    issue_request(make_item(ksr_pkg::MODE_WRITE, '0, '0, addr, '0, '0, '0, '0, '0, b),
                  1'b0, '0);
    random_sent++;
  endtask

  task automatic write_be(logic [31:0] addr, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) write_byte_at(addr + 32'(i), 8'(v >> (8 * (n - 1 - i))));
  endtask

  // Sorted table of records followed by a few linear and binary searches.
  task automatic table_scenario();
    logic [31:0] base;
    logic [31:0] keyv [8];
    logic [31:0] key;
    logic [31:0] opt;
    int          n;
    int          rsize;
    int          koff;
    int          cnt;
    int          j;
    int          kb;
    n     = (1 << $urandom_range(0, 2));
    rsize = $urandom_range(n, n + 4);
    koff  = $urandom_range(0, rsize - n);
    cnt   = $urandom_range(1, 8);
    base  = $urandom_range(0, 3900);
    keyv[0] = $urandom_range(0, 40);
    for (int i = 1; i < cnt; i++) keyv[i] = keyv[i-1] + $urandom_range(1, 50);
    for (int i = 0; i < cnt; i++) write_be(base + i * rsize + koff, keyv[i], n);
    repeat (5) begin
      opt = $urandom_range(0, 7);
      j   = $urandom_range(0, cnt - 1);
      kb  = n;
      if (opt[ksr_pkg::OPT_INDIRECT]) begin
        key = base + j * rsize + koff;
        if ($urandom_range(0, 3) == 0) kb = $urandom_range(0, 20);
      end else begin
        key = ($urandom_range(0, 2) != 0) ? keyv[j] : $urandom_range(0, 300);
        if ($urandom_range(0, 7) == 0) kb = $urandom_range(0, 7);
      end
      issue_request(make_item($urandom_range(0, 1) ? ksr_pkg::MODE_LINEAR
                                                   : ksr_pkg::MODE_BINARY, key,
                              5'(kb), base, 16'(rsize),
                              32'(cnt + $urandom_range(0, 1)), 16'(koff),
                              16'($urandom), 3'(opt), 8'($urandom)), 1'b0, '0);
      random_sent++;
    end
  endtask

  // Linked list of 16-byte nodes; rarely the tail points back to the head.
  task automatic list_scenario();
    logic [31:0] head;
    logic [31:0] keyv [6];
    logic [31:0] next;
    logic [31:0] key;
    logic [31:0] opt;
    int          n;
    int          cnt;
    int          koff;
    int          loff;
    int          j;
    n    = (1 << $urandom_range(0, 2));
    cnt  = $urandom_range(1, 6);
    koff = $urandom_range(0, 3);
    loff = $urandom_range(8, 12);
    head = $urandom_range(1, 3900);
    for (int i = 0; i < cnt; i++) begin
      keyv[i] = $urandom_range(0, 255);
      next = (i < cnt - 1) ? head + (i + 1) * 16 :
             (($urandom_range(0, 24) == 0) ? head : 32'h0);
      write_be(head + i * 16 + koff, keyv[i], n);
      write_be(head + i * 16 + loff, next, 4);
    end
    repeat (4) begin
      opt = $urandom_range(0, 7);
      j   = $urandom_range(0, cnt - 1);
      key = opt[ksr_pkg::OPT_INDIRECT] ? head + j * 16 + koff :
            (($urandom_range(0, 2) != 0) ? keyv[j] : $urandom_range(0, 255));
      issue_request(make_item(ksr_pkg::MODE_LINKED, key, 5'(n), head, 16'($urandom),
                              $urandom, 16'(koff), 16'(loff), 3'(opt), 8'($urandom)),
                    1'b0, '0);
      random_sent++;
    end
  endtask

  typedef struct {
    ksr_pkg::item_t   it;
    bit               typed;
    ksr_pkg::result_t res;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(ksr_pkg::item_t it, bit typed, logic [31:0] v, logic f,
                         logic [1:0] e);
    directed_row_t row;
    row.it    = it;
    row.typed = typed;
    row.res   = make_result(v, f, e);
    directed_rows.push_back(row);
  endtask

  initial begin
    ksr_pkg::item_t noise;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    mismatches  = 0;
    burst_left  = 0;
    random_sent = 0;
    for (int i = 0; i < MEM_SIZE; i++) mem_img[i] = 8'h00;

    // Memory is zero after reset, so a zero key matches the first record.
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h0, 5'd1, 32'd100, 16'd4, 32'd3, 16'd0, 16'd0,
                      3'd0, 8'h00), 1'b1, 32'd100, 1'b1, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h0, 5'd1, 32'd100, 16'd4, 32'd3, 16'd0, 16'd0,
                      3'd4, 8'h00), 1'b1, 32'd0, 1'b1, ksr_pkg::ERR_NONE);
    // Key sizes that are rejected before any memory read.
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h0, 5'd3, 32'd0, 16'd4, 32'd3, 16'd0, 16'd0,
                      3'd0, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_KEY_SIZE);
    add_row(make_item(ksr_pkg::MODE_BINARY, 32'h0, 5'd17, 32'd0, 16'd4, 32'd3, 16'd0, 16'd0,
                      3'd1, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_KEY_SIZE);
    add_row(make_item(ksr_pkg::MODE_LINKED, 32'h0, 5'd31, 32'd0, 16'd4, 32'd3, 16'd0, 16'd0,
                      3'd7, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_KEY_SIZE);
    // Writes outside memory are dropped with an error.
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'h0, 5'd0, 32'd4096, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'hFF), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_BEYOND);
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 16'hFFFF,
                      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF),
            1'b1, 32'd0, 1'b0, ksr_pkg::ERR_BEYOND);
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'h0, 5'd0, 32'd200, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'hFF), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'h0, 5'd0, 32'd4095, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'hA5), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'hFF, 5'd1, 32'd199, 16'd1, 32'd4, 16'd0, 16'd0,
                      3'd4, 8'h00), 1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    // Empty binary range misses; index mode reports all ones.
    add_row(make_item(ksr_pkg::MODE_BINARY, 32'h5, 5'd2, 32'd0, 16'd4, 32'd0, 16'd0, 16'd0,
                      3'd4, 8'h00), 1'b1, 32'hFFFF_FFFF, 1'b0, ksr_pkg::ERR_NONE);
    // A list head of zero is an empty list.
    add_row(make_item(ksr_pkg::MODE_LINKED, 32'h0, 5'd4, 32'd0, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    // A two-byte key straddling the top of memory faults on its second byte.
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h5, 5'd2, 32'd4095, 16'd4, 32'd1, 16'd0, 16'd0,
                      3'd0, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_BEYOND);
    add_row(make_item(ksr_pkg::MODE_BINARY, 32'hFFFF_FFFF, 5'd4, 32'd0, 16'hFFFF,
                      32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3'd0, 8'h00),
            1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    // An empty indirect key matches the first record seen.
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'hFFFF_FFFF, 5'd0, 32'd64, 16'd8, 32'd2, 16'd3,
                      16'd0, 3'd1, 8'h00), 1'b1, 32'd64, 1'b1, ksr_pkg::ERR_NONE);
    // Self-looping node at 300 drives the walk into the step limit.
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'h0, 5'd0, 32'd302, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'h01), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_WRITE, 32'h0, 5'd0, 32'd303, 16'd0, 32'd0, 16'd0, 16'd0,
                      3'd0, 8'h2C), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINKED, 32'h1, 5'd1, 32'd300, 16'd0, 32'd0, 16'd8, 16'd0,
                      3'd4, 8'h00), 1'b1, 32'd0, 1'b0, ksr_pkg::ERR_STEPS);
    add_row(make_item(ksr_pkg::MODE_LINKED, 32'h1, 5'd1, 32'd300, 16'd0, 32'd0, 16'd8, 16'd0,
                      3'd2, 8'h00), 1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h7, 5'd4, 32'd500, 16'd4, 32'd9, 16'd0, 16'd0,
                      3'd6, 8'h00), 1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINEAR, 32'h7, 5'd1, 32'd10, 16'd0, 32'hFFFF_FFFF, 16'd0,
                      16'd0, 3'd4, 8'h00), 1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);
    add_row(make_item(ksr_pkg::MODE_LINKED, 32'h2C, 5'd1, 32'd300, 16'd0, 32'd0, 16'd3, 16'd0,
                      3'd4, 8'h00), 1'b0, 32'd0, 1'b0, ksr_pkg::ERR_NONE);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

    // Mostly well-formed tables and lists with random content, plus noise.
    while (random_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: table_scenario();
        4, 5, 6:    list_scenario();
        default: begin
          noise = ksr_pkg::item_t'($bits(ksr_pkg::item_t)'(
                    {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
          if ($urandom_range(0, 1)) noise.base_address = $urandom_range(0, 4200);
          if ($urandom_range(0, 1)) noise.key_bytes = 5'(1 << $urandom_range(0, 2));
          issue_request(noise, 1'b0, '0);
          random_sent++;
        end
      endcase
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Results are sampled at the edge that ends their single valid cycle.
  always @(posedge clk) begin
    ksr_pkg::result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %h found %0d error %0d",
               result.result_value, result.found, result.error_code);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (result.result_value !== want.result_value) begin
          $error("result_value: expected %h, actual %h",
                 want.result_value, result.result_value);
          mismatches++;
        end
        if (result.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, result.found);
          mismatches++;
        end
        if (result.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code, result.error_code);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any taken request or delivered result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
